>>> design/two_wheel_drive_command_watchdog_assert.svh
// Assertion macros used by the checker of the two-wheel drive command watchdog.
// Depends on nothing; each macro expects a signal named clock and one named reset in scope.
`ifndef TWO_WHEEL_DRIVE_COMMAND_WATCHDOG_ASSERT_SVH
`define TWO_WHEEL_DRIVE_COMMAND_WATCHDOG_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWDW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWDW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/twdw_pkg.sv
// Types and constants of the two-wheel drive command watchdog.
// Used by the wheel lanes, the merge stage and the top level; depends on nothing.
package twdw_pkg;

   localparam int VEL_W  = 16;
   localparam int DUTY_W = 14;
   localparam int DIST_W = 48;
   localparam int MAX_W  = 15;
   localparam int AGE_W  = 16;
   localparam int NUM_W  = 28;   // dividend of the duty division

   localparam logic [12:0] FULL_DUTY = 13'd4096;

   // Drive modes.
   localparam logic [1:0] DM_NONE    = 2'd0;
   localparam logic [1:0] DM_VEL     = 2'd1;
   localparam logic [1:0] DM_PWM     = 2'd2;
   localparam logic [1:0] DM_UNKNOWN = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MAX_SPEED  = 2'd0;
   localparam logic [1:0] CSR_LEFT_FWD   = 2'd1;
   localparam logic [1:0] CSR_RIGHT_FWD  = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT    = 2'd3;

   typedef struct packed {
      logic signed [VEL_W-1:0]  vel;
      logic signed [DUTY_W-1:0] frac;
      logic                     dir;
   } lane_res_type;

   typedef struct packed {
      logic       cmd_en;
      logic       tick_en;
      logic [1:0] dm;
   } upd_type;

   typedef struct packed {
      logic                     is_feedback;
      logic                     left_dir_level;
      logic                     right_dir_level;
      logic signed [DUTY_W-1:0] left_duty;
      logic signed [DUTY_W-1:0] right_duty;
      logic signed [VEL_W-1:0]  left_speed;
      logic signed [VEL_W-1:0]  right_speed;
      logic signed [DIST_W-1:0] left_distance;
      logic signed [DIST_W-1:0] right_distance;
      logic [1:0]               requested_mode;
      logic [1:0]               effective_mode;
   } res_type;

endpackage

>>> design/twdw_lane.sv
// One wheel lane: pwm scaling with rounding and saturation, then a restoring
// divider that forms the duty. Depends on twdw_pkg.
module twdw_lane import twdw_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    use_pwm,
   input  logic signed [VEL_W-1:0] cmd,
   input  logic [MAX_W-1:0]        max_speed,   // never zero here
   input  logic                    fwd_level,
   output logic                    done,
   output lane_res_type            res
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCALE = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [4:0] DIV_LAST = 5'(NUM_W - 1);

   logic [1:0]              state_ff, state_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic                    pwm_ff, pwm_in;
   logic signed [VEL_W-1:0] cmd_ff, cmd_in;
   logic signed [31:0]      prod_ff, prod_in;
   logic signed [VEL_W-1:0] vel_ff, vel_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [MAX_W-1:0]        rem_ff, rem_in;

   logic signed [31:0]      rounded;
   logic signed [31:0]      scaled;
   logic signed [VEL_W-1:0] sat;
   logic signed [VEL_W-1:0] v_sel;
   logic signed [VEL_W:0]   v_ext;
   logic [VEL_W:0]          mag;
   logic [NUM_W-1:0]        num_init;
   logic [MAX_W:0]          trial;
   logic                    ge;
   logic [12:0]             duty_mag;

   assign prod_in = cmd * $signed({1'b0, max_speed});

   // Round to nearest with ties upward: add half, then floor by the shift.
   assign rounded = prod_ff + 32'sd8192;
   assign scaled  = rounded >>> 14;

   always_comb begin
      if (scaled > 32'sd32767) begin
         sat = 16'sh7FFF;
      end else if (scaled < -32'sd32768) begin
         sat = -16'sh8000;
      end else begin
         sat = scaled[VEL_W-1:0];
      end
   end

   assign v_sel    = pwm_ff ? sat : cmd_ff;
   assign v_ext    = {v_sel[VEL_W-1], v_sel};
   assign mag      = v_ext[VEL_W] ? (VEL_W+1)'(-v_ext) : (VEL_W+1)'(v_ext);
   assign num_init = {mag[VEL_W-1:0], 12'b0} + NUM_W'(max_speed >> 1);

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, max_speed};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      pwm_in   = pwm_ff;
      cmd_in   = cmd_ff;
      vel_in   = vel_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pwm_in   = use_pwm;
               cmd_in   = cmd;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            vel_in   = v_sel;
            num_in   = num_init;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // The dividend register fills with quotient bits from the bottom.
            num_in = {num_ff[NUM_W-2:0], ge};
            rem_in = ge ? MAX_W'(trial - {1'b0, max_speed}) : trial[MAX_W-1:0];
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      pwm_ff  <= pwm_in;
      cmd_ff  <= cmd_in;
      vel_ff  <= vel_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      if (state_ff == ST_IDLE && start) begin
         prod_ff <= prod_in;
      end
   end

   assign duty_mag = (num_ff > NUM_W'(FULL_DUTY)) ? FULL_DUTY : num_ff[12:0];

   assign done     = done_ff;
   assign res.vel  = vel_ff;
   assign res.frac = vel_ff[VEL_W-1] ? DUTY_W'(-$signed({1'b0, duty_mag}))
                                     : DUTY_W'({1'b0, duty_mag});
   assign res.dir  = (!vel_ff[VEL_W-1]) == fwd_level;

endmodule

>>> design/twdw_merge.sv
// Merge stage: wheel state, command watchdog and travel accumulators, fed by the
// two lanes; it forms the result of each item. Depends on twdw_pkg.
module twdw_merge import twdw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  upd_type          upd,
   input  lane_res_type     left_res,
   input  lane_res_type     right_res,
   input  logic [AGE_W-1:0] timeout_ticks,
   output res_type          res
);

   logic signed [VEL_W-1:0]  lvel_ff, lvel_in, rvel_ff, rvel_in;
   logic signed [DUTY_W-1:0] lfrac_ff, lfrac_in, rfrac_ff, rfrac_in;
   logic                     ldir_ff, ldir_in, rdir_ff, rdir_in;
   logic [DIST_W-1:0]        ltrav_ff, ltrav_in, rtrav_ff, rtrav_in;
   logic [1:0]               mode_ff, mode_in, eff_ff, eff_in;
   logic [AGE_W-1:0]         age_ff, age_in;
   logic                     fb_ff, fb_in;
   logic [AGE_W-1:0]         age_inc;
   logic                     timed_out;

   assign age_inc   = (age_ff == '1) ? age_ff : age_ff + AGE_W'(1);
   assign timed_out = age_inc > timeout_ticks;

   always_comb begin
      lvel_in  = lvel_ff;
      rvel_in  = rvel_ff;
      lfrac_in = lfrac_ff;
      rfrac_in = rfrac_ff;
      ldir_in  = ldir_ff;
      rdir_in  = rdir_ff;
      ltrav_in = ltrav_ff;
      rtrav_in = rtrav_ff;
      mode_in  = mode_ff;
      eff_in   = eff_ff;
      age_in   = age_ff;
      fb_in    = fb_ff;
      if (upd.cmd_en) begin
         age_in  = '0;
         mode_in = upd.dm;
         eff_in  = upd.dm;
         fb_in   = 1'b0;
         if (upd.dm inside {DM_VEL, DM_PWM}) begin
            lvel_in  = left_res.vel;
            lfrac_in = left_res.frac;
            ldir_in  = left_res.dir;
            rvel_in  = right_res.vel;
            rfrac_in = right_res.frac;
            rdir_in  = right_res.dir;
         end else begin
            lvel_in  = '0;
            rvel_in  = '0;
            lfrac_in = '0;
            rfrac_in = '0;
         end
      end else if (upd.tick_en) begin
         age_in = age_inc;
         fb_in  = 1'b1;
         if (timed_out) begin
            // A halted wheel adds nothing to its travel on this tick.
            lvel_in  = '0;
            rvel_in  = '0;
            lfrac_in = '0;
            rfrac_in = '0;
            eff_in   = DM_NONE;
         end else begin
            ltrav_in = ltrav_ff + DIST_W'(lvel_ff);
            rtrav_in = rtrav_ff + DIST_W'(rvel_ff);
            eff_in   = mode_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvel_ff  <= '0;
         rvel_ff  <= '0;
         lfrac_ff <= '0;
         rfrac_ff <= '0;
         ldir_ff  <= 1'b0;
         rdir_ff  <= 1'b0;
         ltrav_ff <= '0;
         rtrav_ff <= '0;
         mode_ff  <= DM_NONE;
         eff_ff   <= DM_NONE;
         age_ff   <= '0;
         fb_ff    <= 1'b0;
      end else begin
         lvel_ff  <= lvel_in;
         rvel_ff  <= rvel_in;
         lfrac_ff <= lfrac_in;
         rfrac_ff <= rfrac_in;
         ldir_ff  <= ldir_in;
         rdir_ff  <= rdir_in;
         ltrav_ff <= ltrav_in;
         rtrav_ff <= rtrav_in;
         mode_ff  <= mode_in;
         eff_ff   <= eff_in;
         age_ff   <= age_in;
         fb_ff    <= fb_in;
      end
   end

   assign res.is_feedback     = fb_ff;
   assign res.left_dir_level  = ldir_ff;
   assign res.right_dir_level = rdir_ff;
   assign res.left_duty       = lfrac_ff;
   assign res.right_duty      = rfrac_ff;
   assign res.left_speed      = lvel_ff;
   assign res.right_speed     = rvel_ff;
   assign res.left_distance   = $signed(ltrav_ff);
   assign res.right_distance  = $signed(rtrav_ff);
   assign res.requested_mode  = mode_ff;
   assign res.effective_mode  = eff_ff;

endmodule

>>> design/two_wheel_drive_command_watchdog.sv
// Two-wheel drive command watchdog, top level: stream ports, configuration
// registers, sequencing, and the output register. Depends on twdw_pkg, twdw_lane
// and twdw_merge.
//
// Each transfer on the request stream is a drive command (req_tuser low) or a
// feedback tick (req_tuser high) and yields exactly one response. A tick, or a
// command in mode none or unknown, is taken by the merge stage at the transfer
// edge and by the output register once that register is free. For a velocity or
// pwm command both wheel lanes run together: the pwm product is registered at the
// transfer edge, then each lane rounds and saturates, its bit-serial restoring
// divider forms the duty, and the result passes the merge stage and then the
// output register. One item is in work at a time; the next request is taken as
// soon as the previous response sits in the output register, even while that
// response waits for rsp_tready. A max_speed of zero is treated as one.
module two_wheel_drive_command_watchdog import twdw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // Request stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,    // drive_mode[1:0], left_command[17:2], right_command[33:18]
   input  logic         req_tuser,    // mode: 1 feedback tick, 0 drive command
   // Response stream.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [167:0] rsp_tdata,    // left_dir_level[0], right_dir_level[1], left_duty[15:2],
                                      // right_duty[29:16], left_speed[45:30],
                                      // right_speed[61:46], left_distance[109:62],
                                      // right_distance[157:110], requested_mode[159:158],
                                      // effective_mode[161:160]
   output logic         rsp_tuser,    // is_feedback
   // Configuration write port.
   input  logic         csr_wen,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LANES = 2'd1;
   localparam logic [1:0] ST_LOAD  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [1:0]         dm_ff, dm_in;
   logic [MAX_W-1:0]   max_ff;
   logic               lfwd_ff, rfwd_ff;
   logic [AGE_W-1:0]   tmo_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [167:0]       rsp_data_ff;
   logic               rsp_user_ff;

   logic               accept;
   logic               drive_req;
   logic               lanes_done;
   logic               load;
   logic [1:0]         req_dm;
   logic [MAX_W-1:0]   max_eff;
   logic               left_done, right_done;
   lane_res_type       left_res, right_res;
   upd_type            upd;
   res_type            res;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign req_dm     = req_tdata[1:0];
   assign drive_req  = !req_tuser && (req_dm inside {DM_VEL, DM_PWM});
   assign lanes_done = (state_ff == ST_LANES) && left_done && right_done;
   assign load       = (state_ff == ST_LOAD) && (!rsp_valid_ff || rsp_tready);
   assign max_eff    = (max_ff == '0) ? MAX_W'(1) : max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= MAX_W'(256);
         lfwd_ff <= 1'b1;
         rfwd_ff <= 1'b0;
         tmo_ff  <= AGE_W'(25);
      end else if (csr_wen) begin
         case (csr_index)
            CSR_MAX_SPEED: max_ff  <= csr_wdata[MAX_W-1:0];
            CSR_LEFT_FWD:  lfwd_ff <= csr_wdata[0];
            CSR_RIGHT_FWD: rfwd_ff <= csr_wdata[0];
            CSR_TIMEOUT:   tmo_ff  <= csr_wdata[AGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   twdw_lane u_left (
      .clock     (clock),
      .reset     (reset),
      .start     (accept && drive_req),
      .use_pwm   (req_dm == DM_PWM),
      .cmd       ($signed(req_tdata[17:2])),
      .max_speed (max_eff),
      .fwd_level (lfwd_ff),
      .done      (left_done),
      .res       (left_res)
   );

   twdw_lane u_right (
      .clock     (clock),
      .reset     (reset),
      .start     (accept && drive_req),
      .use_pwm   (req_dm == DM_PWM),
      .cmd       ($signed(req_tdata[33:18])),
      .max_speed (max_eff),
      .fwd_level (rfwd_ff),
      .done      (right_done),
      .res       (right_res)
   );

   // Ticks and halting commands update the state in the cycle of their transfer.
   assign upd.cmd_en  = (accept && !req_tuser && !drive_req) || lanes_done;
   assign upd.tick_en = accept && req_tuser;
   assign upd.dm      = (state_ff == ST_LANES) ? dm_ff : req_dm;

   twdw_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .upd           (upd),
      .left_res      (left_res),
      .right_res     (right_res),
      .timeout_ticks (tmo_ff),
      .res           (res)
   );

   always_comb begin
      state_in = state_ff;
      dm_in    = dm_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dm_in    = req_dm;
               state_in = drive_req ? ST_LANES : ST_LOAD;
            end
         end
         ST_LANES: begin
            if (lanes_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dm_ff <= dm_in;
      if (load) begin
         rsp_user_ff <= res.is_feedback;
         rsp_data_ff <= {6'b0, res.effective_mode, res.requested_mode,
                         res.right_distance, res.left_distance,
                         res.right_speed, res.left_speed,
                         res.right_duty, res.left_duty,
                         res.right_dir_level, res.left_dir_level};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> design/twdw_checker.sv
// Port-level checker for the two-wheel drive command watchdog, bound to the top level.
// Depends on the assertion macros in two_wheel_drive_command_watchdog_assert.svh.
`include "two_wheel_drive_command_watchdog_assert.svh"

module twdw_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [167:0] rsp_tdata,
   input logic         rsp_tuser
);

   // A stalled response keeps its payload.
   `TWDW_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // Only one item is in work: a request transfer closes the request side.
   `TWDW_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready, "request taken while busy")

   // Duty stays within full duty in both directions.
   `TWDW_ASSERT_NOW(a_duty_range, rsp_tvalid, ($signed(rsp_tdata[15:2]) <= 14'sd4096) && ($signed(rsp_tdata[15:2]) >= -14'sd4096) && ($signed(rsp_tdata[29:16]) <= 14'sd4096) && ($signed(rsp_tdata[29:16]) >= -14'sd4096), "duty out of range")

   // The left wheel, when at rest, has no duty.
   `TWDW_ASSERT_NOW(a_rest_duty, rsp_tvalid && (rsp_tdata[45:30] == 16'd0), rsp_tdata[15:2] == 14'd0, "duty without speed")

   // A command response never reports a timeout.
   `TWDW_ASSERT_NOW(a_cmd_mode, rsp_tvalid && !rsp_tuser, rsp_tdata[161:160] == rsp_tdata[159:158], "command response shows a timeout")

endmodule

bind two_wheel_drive_command_watchdog twdw_checker u_twdw_checker (.*);
